// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is released.
`define CPCR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property on every rising clock edge while reset is held.
`define CPCR_ASSERT_IN_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) (!rstn) |-> (prop)) else $error(msg);

`endif

// ----- hdl/cpcr_pkg.sv -----
// Shared types, constants and helpers for the circle pair collision core.
// No dependencies.
`default_nettype none

package cpcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DAMP_BITS = 16;
    localparam logic [16:0] DAMP_RESET = 17'd65536;

    // Squared distance below 1e-5 counts as coincident centres
    localparam logic [64:0] EPS_D2 =
        65'(((65'd1 << (2 * FRAC_BITS)) + 65'd99999) / 65'd100000);

    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int DIV_STEPS = 34;
    localparam int DIV_DW    = 64;
    localparam int DIV_NW    = DIV_DW + DIV_STEPS;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               sdx;
        logic               sdy;
        logic [63:0]        d2;
        logic [31:0]        rs;
    } pair_t;

    typedef struct packed {
        logic signed [31:0] vx1;
        logic signed [31:0] vy1;
        logic signed [31:0] vx2;
        logic signed [31:0] vy2;
    } vel4_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end
        else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/circle_pair_collision_response_core.sv -----
// Top level of the two-circle collision response core.
// Depends on cpcr_pkg, cpcr_front, cpcr_fifo and cpcr_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   in       | in_valid / in_stall     | first_* and second_* circle fields
//   out      | out_valid / out_stall   | hit and new_* circle fields
//   cfg      | cfg_wr_en               | cfg_wr_data (damping, Q1.16)
//
// One pair per cycle while the output is not stalled; the longest path to a
// result is the square root then the separation divider in the back pipeline.
// Reset clears control state and loads damping with one; no clearing pass.
// An output stall freezes the back pipeline; the front keeps admitting until
// the eight-entry queue credit is used up, then raises in_stall.
`default_nettype none

module circle_pair_collision_response_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [16:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] first_pos_x,
    input  wire logic signed [31:0] first_pos_y,
    input  wire logic signed [31:0] first_vel_x,
    input  wire logic signed [31:0] first_vel_y,
    input  wire logic [30:0]        first_radius,
    input  wire logic signed [31:0] second_pos_x,
    input  wire logic signed [31:0] second_pos_y,
    input  wire logic signed [31:0] second_vel_x,
    input  wire logic signed [31:0] second_vel_y,
    input  wire logic [30:0]        second_radius,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic signed [31:0]      new_first_pos_x,
    output logic signed [31:0]      new_first_pos_y,
    output logic signed [31:0]      new_first_vel_x,
    output logic signed [31:0]      new_first_vel_y,
    output logic signed [31:0]      new_second_pos_x,
    output logic signed [31:0]      new_second_pos_y,
    output logic signed [31:0]      new_second_vel_x,
    output logic signed [31:0]      new_second_vel_y
);

    logic [16:0]       damp_reg;
    logic              push, pop, empty;
    cpcr_pkg::pair_t   push_data, head;
    cpcr_pkg::res_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            damp_reg <= cpcr_pkg::DAMP_RESET;
        end
        else if (cfg_wr_en) begin
            damp_reg <= cfg_wr_data;
        end
    end

    cpcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_pos_x   (first_pos_x),
        .first_pos_y   (first_pos_y),
        .first_vel_x   (first_vel_x),
        .first_vel_y   (first_vel_y),
        .first_radius  (first_radius),
        .second_pos_x  (second_pos_x),
        .second_pos_y  (second_pos_y),
        .second_vel_x  (second_vel_x),
        .second_vel_y  (second_vel_y),
        .second_radius (second_radius),
        .pop           (pop),
        .push          (push),
        .push_data     (push_data)
    );

    cpcr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .pop   (pop),
        .dout  (head),
        .empty (empty)
    );

    cpcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .damping   (damp_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign hit              = res.hit;
    assign new_first_pos_x  = res.p1x;
    assign new_first_pos_y  = res.p1y;
    assign new_first_vel_x  = res.v1x;
    assign new_first_vel_y  = res.v1y;
    assign new_second_pos_x = res.p2x;
    assign new_second_pos_y = res.p2y;
    assign new_second_vel_x = res.v2x;
    assign new_second_vel_y = res.v2y;

endmodule

`default_nettype wire

// ----- hdl/cpcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cpcr_pkg for widths. Quotient must fit in DIV_STEPS bits.
`default_nettype none

module cpcr_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cpcr_pkg::DIV_NW-1:0]   num,
    input  wire logic [cpcr_pkg::DIV_DW-1:0]   den,
    output logic [cpcr_pkg::DIV_STEPS-1:0]     quo
);

    typedef struct packed {
        logic [cpcr_pkg::DIV_DW-1:0]    rem;
        logic [cpcr_pkg::DIV_STEPS-1:0] sh;
        logic [cpcr_pkg::DIV_DW-1:0]    den;
    } dstage_t;

    dstage_t st_reg [cpcr_pkg::DIV_STEPS];

    function automatic dstage_t div_step(input dstage_t s);
        logic [cpcr_pkg::DIV_DW:0] t;
        logic [cpcr_pkg::DIV_DW:0] d;
        dstage_t                   r;
        t = {s.rem, s.sh[cpcr_pkg::DIV_STEPS-1]};
        d = {1'b0, s.den};
        r.den = s.den;
        if (t >= d) begin
            r.rem = cpcr_pkg::DIV_DW'(t - d);
            r.sh  = {s.sh[cpcr_pkg::DIV_STEPS-2:0], 1'b1};
        end
        else begin
            r.rem = t[cpcr_pkg::DIV_DW-1:0];
            r.sh  = {s.sh[cpcr_pkg::DIV_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    dstage_t first;

    always_comb
    begin
        first.rem = num[cpcr_pkg::DIV_NW-1:cpcr_pkg::DIV_STEPS];
        first.sh  = num[cpcr_pkg::DIV_STEPS-1:0];
        first.den = den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= div_step(first);
            for (int i = 1; i < cpcr_pkg::DIV_STEPS; i++)
            begin
                st_reg[i] <= div_step(st_reg[i-1]);
            end
        end
    end

    assign quo = st_reg[cpcr_pkg::DIV_STEPS-1].sh;

endmodule

`default_nettype wire

// ----- hdl/cpcr_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on cpcr_pkg for the stage count.
`default_nettype none

module cpcr_sqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] rad,
    output logic [31:0]      root
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sstage_t;

    sstage_t st_reg [cpcr_pkg::SQRT_STEPS];

    function automatic sstage_t sqrt_step(input sstage_t s);
        logic [35:0] r;
        logic [35:0] trial;
        sstage_t     n;
        r     = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        n.rad = {s.rad[61:0], 2'b00};
        if (r >= trial) begin
            n.rem  = 34'(r - trial);
            n.root = {s.root[30:0], 1'b1};
        end
        else begin
            n.rem  = r[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    sstage_t first;

    always_comb
    begin
        first.rem  = '0;
        first.root = '0;
        first.rad  = rad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sqrt_step(first);
            for (int i = 1; i < cpcr_pkg::SQRT_STEPS; i++)
            begin
                st_reg[i] <= sqrt_step(st_reg[i-1]);
            end
        end
    end

    assign root = st_reg[cpcr_pkg::SQRT_STEPS-1].root;

endmodule

`default_nettype wire

// ----- hdl/cpcr_front.sv -----
// Front end: accepts circle pairs, forms distances and classifies overlap.
// Depends on cpcr_pkg; feeds cpcr_fifo and owns the admission credit count.
`default_nettype none

module cpcr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] first_pos_x,
    input  wire logic signed [31:0] first_pos_y,
    input  wire logic signed [31:0] first_vel_x,
    input  wire logic signed [31:0] first_vel_y,
    input  wire logic [30:0]        first_radius,
    input  wire logic signed [31:0] second_pos_x,
    input  wire logic signed [31:0] second_pos_y,
    input  wire logic signed [31:0] second_vel_x,
    input  wire logic signed [31:0] second_vel_y,
    input  wire logic [30:0]        second_radius,
    input  wire logic               pop,
    output logic                    push,
    output cpcr_pkg::pair_t         push_data
);

    logic                 accept;
    logic [cpcr_pkg::QCW-1:0] cnt_reg, cnt_next;

    logic                 f1_vld_reg, f2_vld_reg;
    cpcr_pkg::pair_t      f1_reg, f2_reg;
    logic                 f1_big_reg, f2_big_reg;
    logic [63:0]          sqx_reg, sqy_reg, rs2_reg;

    logic signed [32:0]   dx, dy;
    logic [32:0]          ax, ay;
    logic [64:0]          d2;

    assign in_stall = (cnt_reg == cpcr_pkg::QCW'(cpcr_pkg::QDEPTH));
    assign accept   = in_valid && !in_stall;

    // Count items admitted but not yet handed to the back end
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            f1_vld_reg <= accept;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_comb
    begin
        dx = {first_pos_x[31], first_pos_x} - {second_pos_x[31], second_pos_x};
        dy = {first_pos_y[31], first_pos_y} - {second_pos_y[31], second_pos_y};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
    end

    always_ff @(posedge clk)
    begin
        f1_reg.hit <= 1'b0;
        f1_reg.p1x <= first_pos_x;
        f1_reg.p1y <= first_pos_y;
        f1_reg.v1x <= first_vel_x;
        f1_reg.v1y <= first_vel_y;
        f1_reg.p2x <= second_pos_x;
        f1_reg.p2y <= second_pos_y;
        f1_reg.v2x <= second_vel_x;
        f1_reg.v2y <= second_vel_y;
        f1_reg.ax  <= ax[31:0];
        f1_reg.ay  <= ay[31:0];
        f1_reg.sdx <= dx[32];
        f1_reg.sdy <= dy[32];
        f1_reg.d2  <= '0;
        f1_reg.rs  <= {1'b0, first_radius} + {1'b0, second_radius};
        f1_big_reg <= ax[32] | ay[32];

        f2_reg     <= f1_reg;
        f2_big_reg <= f1_big_reg;
        sqx_reg    <= f1_reg.ax * f1_reg.ax;
        sqy_reg    <= f1_reg.ay * f1_reg.ay;
        rs2_reg    <= f1_reg.rs * f1_reg.rs;
    end

    always_comb
    begin
        d2            = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        push          = f2_vld_reg;
        push_data     = f2_reg;
        push_data.d2  = d2[63:0];
        // Overlapping and not coincident; a far pair never qualifies
        push_data.hit = !f2_big_reg && (d2 < {1'b0, rs2_reg})
                        && (d2 >= cpcr_pkg::EPS_D2);
    end

endmodule

`default_nettype wire

// ----- hdl/cpcr_fifo.sv -----
// Short queue between the front end and the back end.
// Depends on cpcr_pkg; admission credit upstream prevents overflow.
`default_nettype none

module cpcr_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  cpcr_pkg::pair_t      din,
    input  wire logic            pop,
    output cpcr_pkg::pair_t      dout,
    output logic                 empty
);

    cpcr_pkg::pair_t              mem_reg [cpcr_pkg::QDEPTH];
    logic [cpcr_pkg::QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [cpcr_pkg::QCW-1:0]     cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);

endmodule

`default_nettype wire

// ----- hdl/cpcr_back.sv -----
// Back end: impulse, damping and separation pipeline with output register.
// Depends on cpcr_pkg, cpcr_div and cpcr_sqrt.
`default_nettype none

module cpcr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  cpcr_pkg::pair_t    head,
    input  wire logic          empty,
    output logic               pop,
    input  wire logic [16:0]   damping,
    output logic               out_valid,
    input  wire logic          out_stall,
    output cpcr_pkg::res_t     res
);

    localparam int L_NUM  = 4;
    localparam int L_Q1   = L_NUM + cpcr_pkg::DIV_STEPS;
    localparam int L_VEL  = L_Q1 + 3;
    localparam int L_SQ   = cpcr_pkg::SQRT_STEPS;
    localparam int L_SEPN = L_SQ + 2;
    localparam int L_Q2   = L_SEPN + cpcr_pkg::DIV_STEPS;
    localparam int LAST   = L_Q2 + 1;

    logic en;

    logic               vld_reg [LAST+1];
    cpcr_pkg::pair_t    itm_reg [L_Q2+1];
    logic               dneg_reg [3:L_Q1];
    cpcr_pkg::vel4_t    velq_reg [L_VEL:L_Q2];

    logic [63:0]        px_reg, py_reg;
    logic               pxn_reg, pyn_reg;
    logic signed [65:0] dot_reg;
    logic [63:0]        plx_reg, ply_reg;
    logic [64:0]        phx_reg, phy_reg;
    logic [cpcr_pkg::DIV_NW-1:0] nx_reg, ny_reg;
    logic [cpcr_pkg::DIV_STEPS-1:0] qx, qy, qsx, qsy;

    logic [34:0]        vm_reg [4];
    logic               vs1_reg [4];
    logic [51:0]        vp_reg [4];
    logic               vs2_reg [4];

    logic [31:0]        root;
    logic [31:0]        ov_reg, dist_reg;
    logic [cpcr_pkg::DIV_NW-1:0] snx_reg, sny_reg;
    logic [cpcr_pkg::DIV_DW-1:0] sden_reg;
    cpcr_pkg::res_t     res_reg;

    // stage one comb
    logic signed [32:0] vdx, vdy;
    logic [31:0]        mvx, mvy;
    logic signed [65:0] tx, ty;
    logic [65:0]        dmag;
    // velocity comb
    logic signed [35:0] ix36, iy36;
    logic signed [35:0] w [4];
    logic [34:0]        vm_next [4];
    logic [35:0]        vt [4];
    logic signed [39:0] vsg [4];
    cpcr_pkg::vel4_t    vel_next;
    // final comb
    logic signed [35:0] sx36, sy36;
    cpcr_pkg::pair_t    fin;
    cpcr_pkg::res_t     res_next;

    assign en        = !(vld_reg[LAST] && out_stall);
    assign pop       = en && !empty;
    assign out_valid = vld_reg[LAST];
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !empty;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb
    begin
        vdx  = {itm_reg[0].v1x[31], itm_reg[0].v1x} - {itm_reg[0].v2x[31], itm_reg[0].v2x};
        vdy  = {itm_reg[0].v1y[31], itm_reg[0].v1y} - {itm_reg[0].v2y[31], itm_reg[0].v2y};
        mvx  = vdx[32] ? 32'(-vdx) : vdx[31:0];
        mvy  = vdy[32] ? 32'(-vdy) : vdy[31:0];
        tx   = pxn_reg ? -$signed({2'b00, px_reg}) : $signed({2'b00, px_reg});
        ty   = pyn_reg ? -$signed({2'b00, py_reg}) : $signed({2'b00, py_reg});
        dmag = dot_reg[65] ? 66'(-dot_reg) : 66'(dot_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            itm_reg[0] <= head;
            for (int i = 1; i <= L_Q2; i++)
            begin
                itm_reg[i] <= itm_reg[i-1];
            end
            // dot product of velocity difference and centre offset
            px_reg  <= mvx * itm_reg[0].ax;
            py_reg  <= mvy * itm_reg[0].ay;
            pxn_reg <= vdx[32] ^ itm_reg[0].sdx;
            pyn_reg <= vdy[32] ^ itm_reg[0].sdy;
            dot_reg <= tx + ty;
            // split the wide magnitude into two partial products
            plx_reg <= dmag[31:0] * itm_reg[2].ax;
            phx_reg <= dmag[64:32] * itm_reg[2].ax;
            ply_reg <= dmag[31:0] * itm_reg[2].ay;
            phy_reg <= dmag[64:32] * itm_reg[2].ay;
            nx_reg  <= cpcr_pkg::DIV_NW'({phx_reg, 32'h0}) + cpcr_pkg::DIV_NW'(plx_reg);
            ny_reg  <= cpcr_pkg::DIV_NW'({phy_reg, 32'h0}) + cpcr_pkg::DIV_NW'(ply_reg);
            dneg_reg[3] <= dot_reg[65];
            for (int i = 4; i <= L_Q1; i++)
            begin
                dneg_reg[i] <= dneg_reg[i-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                vm_reg[k]  <= vm_next[k];
                vs1_reg[k] <= w[k][35];
                vp_reg[k]  <= vm_reg[k] * damping;
                vs2_reg[k] <= vs1_reg[k];
            end
            velq_reg[L_VEL] <= vel_next;
            for (int i = L_VEL + 1; i <= L_Q2; i++)
            begin
                velq_reg[i] <= velq_reg[i-1];
            end
            // separation path
            ov_reg   <= itm_reg[L_SQ].rs - root;
            dist_reg <= root;
            snx_reg  <= cpcr_pkg::DIV_NW'(itm_reg[L_SQ+1].ax * ov_reg);
            sny_reg  <= cpcr_pkg::DIV_NW'(itm_reg[L_SQ+1].ay * ov_reg);
            sden_reg <= cpcr_pkg::DIV_DW'({dist_reg, 1'b0});
            res_reg  <= res_next;
        end
    end

    cpcr_div u_div_ix (.clk(clk), .en(en), .num(nx_reg), .den(itm_reg[L_NUM].d2), .quo(qx));
    cpcr_div u_div_iy (.clk(clk), .en(en), .num(ny_reg), .den(itm_reg[L_NUM].d2), .quo(qy));
    cpcr_sqrt u_sqrt (.clk(clk), .en(en), .rad(itm_reg[0].d2), .root(root));
    cpcr_div u_div_sx (.clk(clk), .en(en), .num(snx_reg), .den(sden_reg), .quo(qsx));
    cpcr_div u_div_sy (.clk(clk), .en(en), .num(sny_reg), .den(sden_reg), .quo(qsy));

    always_comb
    begin
        ix36 = $signed({2'b00, qx});
        iy36 = $signed({2'b00, qy});
        if (dneg_reg[L_Q1] ^ itm_reg[L_Q1].sdx) begin
            ix36 = -ix36;
        end
        if (dneg_reg[L_Q1] ^ itm_reg[L_Q1].sdy) begin
            iy36 = -iy36;
        end
        w[0] = $signed({{4{itm_reg[L_Q1].v1x[31]}}, itm_reg[L_Q1].v1x}) - ix36;
        w[1] = $signed({{4{itm_reg[L_Q1].v1y[31]}}, itm_reg[L_Q1].v1y}) - iy36;
        w[2] = $signed({{4{itm_reg[L_Q1].v2x[31]}}, itm_reg[L_Q1].v2x}) + ix36;
        w[3] = $signed({{4{itm_reg[L_Q1].v2y[31]}}, itm_reg[L_Q1].v2y}) + iy36;
        for (int k = 0; k < 4; k++)
        begin
            vm_next[k] = w[k][35] ? 35'(-w[k]) : 35'(w[k]);
            vt[k]      = vp_reg[k][51:cpcr_pkg::DAMP_BITS];
            vsg[k]     = $signed({4'b0000, vt[k]});
            if (vs2_reg[k]) begin
                vsg[k] = -vsg[k];
            end
        end
        vel_next.vx1 = cpcr_pkg::sat32(vsg[0]);
        vel_next.vy1 = cpcr_pkg::sat32(vsg[1]);
        vel_next.vx2 = cpcr_pkg::sat32(vsg[2]);
        vel_next.vy2 = cpcr_pkg::sat32(vsg[3]);
    end

    always_comb
    begin
        fin  = itm_reg[L_Q2];
        sx36 = $signed({2'b00, qsx});
        sy36 = $signed({2'b00, qsy});
        if (fin.sdx) begin
            sx36 = -sx36;
        end
        if (fin.sdy) begin
            sy36 = -sy36;
        end
        res_next.hit = fin.hit;
        res_next.p1x = fin.p1x;
        res_next.p1y = fin.p1y;
        res_next.v1x = fin.v1x;
        res_next.v1y = fin.v1y;
        res_next.p2x = fin.p2x;
        res_next.p2y = fin.p2y;
        res_next.v2x = fin.v2x;
        res_next.v2y = fin.v2y;
        if (fin.hit)
        begin
            res_next.v1x = velq_reg[L_Q2].vx1;
            res_next.v1y = velq_reg[L_Q2].vy1;
            res_next.v2x = velq_reg[L_Q2].vx2;
            res_next.v2y = velq_reg[L_Q2].vy2;
            res_next.p1x = cpcr_pkg::sat32($signed({{8{fin.p1x[31]}}, fin.p1x})
                                           + $signed({{4{sx36[35]}}, sx36}));
            res_next.p1y = cpcr_pkg::sat32($signed({{8{fin.p1y[31]}}, fin.p1y})
                                           + $signed({{4{sy36[35]}}, sy36}));
            res_next.p2x = cpcr_pkg::sat32($signed({{8{fin.p2x[31]}}, fin.p2x})
                                           - $signed({{4{sx36[35]}}, sx36}));
            res_next.p2y = cpcr_pkg::sat32($signed({{8{fin.p2y[31]}}, fin.p2y})
                                           - $signed({{4{sy36[35]}}, sy36}));
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cpcr_checker.sv -----
// Port-level checks for the collision core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cpcr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               hit,
    input wire logic signed [31:0] new_first_pos_x
);

    // hold a stalled result
    `CPCR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `CPCR_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(hit) && $stable(new_first_pos_x), "stalled result changed")
    // credit fills only through an accepted transaction
    `CPCR_ASSERT(a_stall_rise, clk, rst_n, $rose(in_stall) |-> $past(in_valid), "stall raised without a transaction")
    `CPCR_ASSERT_IN_RST(a_rst_quiet, clk, rst_n, !out_valid && !in_stall, "activity during reset")

endmodule

bind circle_pair_collision_response_core cpcr_checker u_cpcr_checker (.*);

`default_nettype wire
